/* src/mcr_pkg.sv */
// Shared widths, codes and types for the midpoint circle rasterizer.
package mcr_pkg;

  // Field widths of the channels.
  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned RADIUS_W = 9;
  localparam int unsigned ADDR_W   = 20;

  // Internal widths.
  localparam int unsigned POS_W  = 10;
  localparam int unsigned DEC_W  = 12;
  localparam int unsigned PROD_W = 21;
  localparam int unsigned SUM_W  = 23;
  localparam int unsigned OCT_W  = 3;

  // Frame width limit and reset value.
  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(1024);
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(512);

  // Action codes of an input item.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Index of the final octant of a step.
  localparam logic [OCT_W-1:0] OCT_LAST = OCT_W'(7);

  // Geometry of one step, held while its eight addresses go out.
  typedef struct packed {
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [PROD_W-1:0] col_w;
    logic [PROD_W-1:0] row_w;
  } step_geom_t;

  // Frame constants derived from the width register.
  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [PROD_W-1:0]  area;
    logic [PROD_W-1:0]  centre;
  } frame_t;

endpackage

/* src/mcr_cfg_if.sv */
// Configuration write channel carrying the frame width.
interface mcr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mcr_pkg::WIDTH_W-1:0] frame_width;

  modport source (output valid, output frame_width, input ready);
  modport sink (input valid, input frame_width, output ready);
endinterface

/* src/mcr_in_if.sv */
// Input item channel: action code and radius.
interface mcr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [mcr_pkg::RADIUS_W-1:0] radius;

  modport source (output valid, output action, output radius, input ready);
  modport sink (input valid, input action, input radius, output ready);
endinterface

/* src/mcr_out_if.sv */
// Result channel: pixel address and its flags.
interface mcr_out_if;
  logic                       valid;
  logic                       ready;
  logic [mcr_pkg::ADDR_W-1:0] pixel_address;
  logic                       out_of_frame;
  logic                       last_of_run;
  logic                       finished;

  modport source (
    output valid, output pixel_address, output out_of_frame,
    output last_of_run, output finished, input ready
  );
  modport sink (
    input valid, input pixel_address, input out_of_frame,
    input last_of_run, input finished, output ready
  );
endinterface

/* src/mcr_addr_unit.sv */
// Address of one octant pixel and its frame bounds check.
module mcr_addr_unit (
  input  logic [mcr_pkg::OCT_W-1:0]  oct_i,
  input  mcr_pkg::step_geom_t        geom_i,
  input  mcr_pkg::frame_t            frame_i,
  output logic [mcr_pkg::ADDR_W-1:0] addr_o,
  output logic                       oof_o
);

  logic                             use_col_w;
  logic                             neg_prod;
  logic                             sub_width;
  logic                             neg_ofs;
  logic                             dec_one;
  logic signed [mcr_pkg::SUM_W-1:0] prod_s;
  logic signed [mcr_pkg::SUM_W-1:0] ofs_s;
  logic signed [mcr_pkg::SUM_W-1:0] sum_s;

  // Octant decode. Octants 0, 1, 4 and 5 use the row product and the column
  // offset; the others swap them. Odd octants subtract the product, even
  // ones subtract one frame width instead. The offset is negated in octants
  // 1, 3, 4 and 6, and the remaining octants take the extra minus one.
  always_comb begin
    use_col_w = oct_i[1];
    neg_prod  = oct_i[0];
    sub_width = ~oct_i[0];
    neg_ofs   = oct_i[0] ^ oct_i[2];
    dec_one   = ~(oct_i[0] ^ oct_i[2]);
  end

  // Five-term sum in signed arithmetic wide enough for every case.
  always_comb begin
    prod_s = use_col_w ? $signed({2'b00, geom_i.col_w}) : $signed({2'b00, geom_i.row_w});
    ofs_s  = use_col_w ? $signed(mcr_pkg::SUM_W'(geom_i.row))
                       : $signed(mcr_pkg::SUM_W'(geom_i.col));
    sum_s  = $signed({2'b00, frame_i.centre})
           + (neg_prod ? -prod_s : prod_s)
           + (neg_ofs ? -ofs_s : ofs_s)
           - (sub_width ? $signed(mcr_pkg::SUM_W'(frame_i.width))
                        : $signed(mcr_pkg::SUM_W'(0)))
           - (dec_one ? $signed(mcr_pkg::SUM_W'(1)) : $signed(mcr_pkg::SUM_W'(0)));
  end

  // The frame area never exceeds the 20-bit address space, so one compare
  // against it also covers the address width.
  always_comb begin
    oof_o  = sum_s[mcr_pkg::SUM_W-1]
           || (sum_s >= $signed({2'b00, frame_i.area}));
    addr_o = oof_o ? '0 : sum_s[mcr_pkg::ADDR_W-1:0];
  end

endmodule

/* src/midpoint_circle_rasterizer_core.sv */
// Top level of the midpoint circle rasterizer core.
//
//   channel | direction | transfer carries
//   cfg_i   | in        | frame_width (11 bits)
//   in_i    | in        | action (1 bit), radius (9 bits)
//   out_o   | out       | pixel_address (20), out_of_frame, last_of_run, finished
//
// A start item gives no result. A step item gives eight results, one a
// cycle while out_o does not stall, from a single octant address adder;
// a step that finishes the circle gives one.
// The next item is accepted in the cycle its predecessor's last result is
// loaded into the output register. Reset sets the width to 512 and idles.
// Stalls on out_o hold the output register and hold off further input.
module midpoint_circle_rasterizer_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcr_cfg_if.sink   cfg_i,
  mcr_in_if.sink    in_i,
  mcr_out_if.source out_o
);

  // Circle state.
  logic [mcr_pkg::POS_W-1:0]   col_q, col_d;
  logic [mcr_pkg::POS_W-1:0]   row_q, row_d;
  logic [mcr_pkg::DEC_W-1:0]   dec_q, dec_d;
  logic                        active_q, active_d;

  // Frame configuration.
  logic [mcr_pkg::WIDTH_W-1:0] width_q;
  logic [mcr_pkg::WIDTH_W-1:0] width_clamped;
  mcr_pkg::frame_t             frame_q;

  // Pending job.
  logic                        job_vld_q;
  logic                        job_fin_q;
  logic [mcr_pkg::OCT_W-1:0]   oct_q;
  mcr_pkg::step_geom_t         geom_q, geom_d;

  // Output register.
  logic                        out_vld_q;
  logic [mcr_pkg::ADDR_W-1:0]  addr_q;
  logic                        oof_q;
  logic                        last_q;
  logic                        fin_q;

  logic                        emit_go;
  logic                        job_last;
  logic                        in_fire;
  logic                        is_step;
  logic                        is_start;
  logic                        do_advance;
  logic [mcr_pkg::ADDR_W-1:0]  oct_addr;
  logic                        oct_oof;

  // Handshakes.
  assign emit_go     = job_vld_q && (!out_vld_q || out_o.ready);
  assign job_last    = job_fin_q || (oct_q == mcr_pkg::OCT_LAST);
  assign in_i.ready  = !job_vld_q || (emit_go && job_last);
  assign in_fire     = in_i.valid && in_i.ready;
  assign is_step     = in_fire && (in_i.action == mcr_pkg::ACT_STEP);
  assign is_start    = in_fire && (in_i.action == mcr_pkg::ACT_START);
  assign do_advance  = is_step && active_q && (row_q > col_q);
  assign cfg_i.ready = 1'b1;

  // Clamp the width to the largest supported frame.
  assign width_clamped = (width_q > mcr_pkg::MAX_WIDTH) ? mcr_pkg::MAX_WIDTH : width_q;

  // Midpoint decision: east when negative, otherwise south-east.
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    dec_d    = dec_q;
    active_d = active_q;
    if (is_start) begin
      col_d    = '0;
      row_d    = mcr_pkg::POS_W'(in_i.radius);
      dec_d    = mcr_pkg::DEC_W'(1) - mcr_pkg::DEC_W'(in_i.radius);
      active_d = 1'b1;
    end else if (do_advance) begin
      if (dec_q[mcr_pkg::DEC_W-1]) begin
        dec_d = dec_q + mcr_pkg::DEC_W'({col_q, 1'b0}) + mcr_pkg::DEC_W'(3);
      end else begin
        dec_d = dec_q + mcr_pkg::DEC_W'({col_q, 1'b0}) - mcr_pkg::DEC_W'({row_q, 1'b0})
              + mcr_pkg::DEC_W'(5);
        row_d = row_q - mcr_pkg::POS_W'(1);
      end
      col_d = col_q + mcr_pkg::POS_W'(1);
    end else if (is_step) begin
      active_d = 1'b0;
    end
  end

  // Row and column products for the new position, used by all octants.
  always_comb begin
    geom_d.col   = col_d;
    geom_d.row   = row_d;
    geom_d.col_w = mcr_pkg::PROD_W'(col_d) * mcr_pkg::PROD_W'(width_clamped);
    geom_d.row_w = mcr_pkg::PROD_W'(row_d) * mcr_pkg::PROD_W'(width_clamped);
  end

  mcr_addr_unit u_addr (
    .oct_i   (oct_q),
    .geom_i  (geom_q),
    .frame_i (frame_q),
    .addr_o  (oct_addr),
    .oof_o   (oct_oof)
  );

  // Frame area and centre are registered from the clamped width register.
  always_ff @(posedge clk_i) begin
    frame_q.width  <= width_clamped;
    frame_q.area   <= mcr_pkg::PROD_W'(width_clamped) * mcr_pkg::PROD_W'(width_clamped);
    frame_q.centre <= (mcr_pkg::PROD_W'(width_clamped) * mcr_pkg::PROD_W'(width_clamped) >> 1)
                    - mcr_pkg::PROD_W'(width_clamped >> 1);
  end

  // Control state, circle state and the width register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      dec_q     <= '0;
      active_q  <= 1'b0;
      width_q   <= mcr_pkg::WIDTH_RESET;
      job_vld_q <= 1'b0;
      job_fin_q <= 1'b0;
      oct_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      dec_q    <= dec_d;
      active_q <= active_d;
      if (cfg_i.valid) begin
        width_q <= cfg_i.frame_width;
      end
      // Job slot: loaded by a step, emptied by its last result.
      if (is_step) begin
        job_vld_q <= 1'b1;
        job_fin_q <= !do_advance;
        oct_q     <= '0;
      end else if (emit_go) begin
        if (job_last) begin
          job_vld_q <= 1'b0;
        end
        oct_q <= oct_q + mcr_pkg::OCT_W'(1);
      end
      // Output valid.
      if (emit_go) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (do_advance) begin
      geom_q <= geom_d;
    end
    if (emit_go) begin
      addr_q <= job_fin_q ? '0 : oct_addr;
      oof_q  <= job_fin_q ? 1'b0 : oct_oof;
      last_q <= job_last;
      fin_q  <= job_fin_q;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.pixel_address = addr_q;
  assign out_o.out_of_frame  = oof_q;
  assign out_o.last_of_run   = last_q;
  assign out_o.finished      = fin_q;

endmodule
